>>> design/grid_boundary_index_generator_defines.svh
// Assertion macros for the grid boundary index generator checker.
`ifndef GRID_BOUNDARY_INDEX_GENERATOR_DEFINES_SVH
`define GRID_BOUNDARY_INDEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define GBIG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbig checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is low.
`define GBIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbig checker: next-cycle property failed");

`endif

>>> design/gbig_pkg.sv
package gbig_pkg;

    localparam int MAX_BASIS_PER_DIR = 8;
    localparam int CNT_W             = 4;   // count register width
    localparam int IDX_W             = 9;   // basis index width
    localparam int PLANE_W           = 7;   // nu*nv, at most 64
    localparam int POS_W             = 3;   // position along one axis
    localparam int VTX_W             = 3;   // vertex number
    localparam int ADDR_W            = 4;   // APB address
    localparam int DATA_W            = 32;  // APB data

    typedef enum logic [2:0] {
        MODE_VERTEX       = 3'd0,
        MODE_EDGE_RUN     = 3'd1,
        MODE_FACE_RUN     = 3'd2,
        MODE_EDGE_ENDS    = 3'd3,
        MODE_FACE_CORNERS = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        REG_COUNT_U = 2'd0,
        REG_COUNT_V = 2'd1,
        REG_COUNT_W = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        AXIS_U = 2'd0,
        AXIS_V = 2'd1,
        AXIS_W = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        ASEL_ZERO = 2'd0,
        ASEL_ACC  = 2'd1,
        ASEL_ROW  = 2'd2
    } t_asel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLANE,
        S_OFFS,
        S_VX0,
        S_VX1,
        S_VX2,
        S_PUT,
        S_WALK,
        S_BAD
    } t_state;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] selector;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] basis_index;
        logic             row_end;
        logic             last;
        logic             bad_request;
    } t_out_word;

    // clamped grid sizes
    typedef struct packed {
        logic [CNT_W-1:0] nu;
        logic [CNT_W-1:0] nv;
        logic [CNT_W-1:0] nw;
    } t_dims;

    // control of the shared adder
    typedef struct packed {
        t_asel            a_sel;
        logic [IDX_W-1:0] b;
        logic             load_acc;
        logic             load_row;
    } t_add_ctl;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (c > CNT_W'(MAX_BASIS_PER_DIR)) begin
            r = CNT_W'(MAX_BASIS_PER_DIR);
        end
        return r;
    endfunction

    function automatic logic req_ok(input logic [2:0] mode, input logic [3:0] sel);
        logic ok;
        case (mode)
            MODE_VERTEX:       ok = (sel < 4'd8);
            MODE_EDGE_RUN:     ok = (sel < 4'd12);
            MODE_FACE_RUN:     ok = (sel < 4'd6);
            MODE_EDGE_ENDS:    ok = (sel < 4'd12);
            MODE_FACE_CORNERS: ok = (sel < 4'd6);
            default:           ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic t_axis edge_axis_of(input logic [3:0] sel);
        t_axis a;
        case (sel)
            4'd0, 4'd1, 4'd4, 4'd5: a = AXIS_U;
            4'd2, 4'd3, 4'd6, 4'd7: a = AXIS_W;
            default:                a = AXIS_V;
        endcase
        return a;
    endfunction

    function automatic logic [VTX_W-1:0] edge_first_of(input logic [3:0] sel);
        logic [VTX_W-1:0] v;
        case (sel)
            4'd0:    v = 3'd0;
            4'd1:    v = 3'd2;
            4'd2:    v = 3'd0;
            4'd3:    v = 3'd1;
            4'd4:    v = 3'd4;
            4'd5:    v = 3'd6;
            4'd6:    v = 3'd4;
            4'd7:    v = 3'd5;
            4'd8:    v = 3'd0;
            4'd9:    v = 3'd1;
            4'd10:   v = 3'd2;
            4'd11:   v = 3'd3;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic logic [VTX_W-1:0] edge_second_of(input logic [3:0] sel);
        logic [VTX_W-1:0] v;
        case (sel)
            4'd0:    v = 3'd1;
            4'd1:    v = 3'd3;
            4'd2:    v = 3'd2;
            4'd3:    v = 3'd3;
            4'd4:    v = 3'd5;
            4'd5:    v = 3'd7;
            4'd6:    v = 3'd6;
            4'd7:    v = 3'd7;
            4'd8:    v = 3'd4;
            4'd9:    v = 3'd5;
            4'd10:   v = 3'd6;
            4'd11:   v = 3'd7;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic t_axis face_outer_of(input logic [3:0] sel);
        return (sel < 4'd2) ? AXIS_W : AXIS_V;
    endfunction

    function automatic t_axis face_inner_of(input logic [3:0] sel);
        return (sel == 4'd2 || sel == 4'd3) ? AXIS_W : AXIS_U;
    endfunction

    function automatic logic [VTX_W-1:0] face_base_of(input logic [3:0] sel);
        logic [VTX_W-1:0] v;
        case (sel)
            4'd1:    v = 3'd4;
            4'd3:    v = 3'd1;
            4'd5:    v = 3'd2;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic logic [VTX_W-1:0] face_corner_of(input logic [3:0] sel,
                                                        input logic [1:0] p);
        logic [4*VTX_W-1:0] row;
        case (sel)
            4'd0:    row = {3'd0, 3'd1, 3'd3, 3'd2};
            4'd1:    row = {3'd4, 3'd5, 3'd7, 3'd6};
            4'd2:    row = {3'd0, 3'd2, 3'd6, 3'd4};
            4'd3:    row = {3'd1, 3'd3, 3'd7, 3'd5};
            4'd4:    row = {3'd0, 3'd1, 3'd5, 3'd4};
            4'd5:    row = {3'd2, 3'd3, 3'd7, 3'd6};
            default: row = '0;
        endcase
        return row[(3 - p) * VTX_W +: VTX_W];
    endfunction

    // vertex number of the p-th vertex a request needs
    function automatic logic [VTX_W-1:0] vertex_of(input t_mode mode,
                                                   input logic [3:0] sel,
                                                   input logic [1:0] p);
        logic [VTX_W-1:0] v;
        case (mode)
            MODE_VERTEX:       v = sel[VTX_W-1:0];
            MODE_EDGE_RUN:     v = edge_first_of(sel);
            MODE_FACE_RUN:     v = face_base_of(sel);
            MODE_EDGE_ENDS:    v = p[0] ? edge_second_of(sel) : edge_first_of(sel);
            MODE_FACE_CORNERS: v = face_corner_of(sel, p);
            default:           v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/grid_boundary_index_generator.sv
// Channel   Direction  Handshake                 Word
// request   in         i_in_valid / o_in_stall   i_in_word  (mode, selector)
// result    out        o_out_valid / i_out_stall o_out_word (basis_index, row_end,
//                                                            last, bad_request)
// config    in         APB psel/penable/pwrite   count_u @0, count_v @4, count_w @8
//
// Each vertex costs three passes through the single adder; a run then gives one
//   index a cycle from that same adder while the result register can take it.
// Reset: synchronous, active low; counts return to 2, sequencer idle, result
//   register empty. No memory, no clearing pass.
// A stalled result holds the sequencer in its emit state; the request side
//   is stalled for the whole burst.
module grid_boundary_index_generator
    import gbig_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_dims            dims;
    t_add_ctl         add_ctl;
    logic [IDX_W-1:0] acc;
    logic             busy;
    logic             start;
    logic             out_free;
    logic             emit;
    t_out_word        emit_word;

    logic             r_out_valid;
    t_out_word        r_out_word;

    // zero-wait APB
    assign pready = 1'b1;

    gbig_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_dims  (dims)
    );

    // the one adder: vertex assembly and run stepping share it
    gbig_addu u_addu (
        .i_clk (i_clk),
        .i_ctl (add_ctl),
        .o_acc (acc)
    );

    // request accepted only while the sequencer sits idle
    assign start    = i_in_valid & ~busy;
    // result slot is free when empty or being drained this cycle
    assign out_free = ~r_out_valid | ~i_out_stall;

    gbig_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_in_word),
        .i_dims      (dims),
        .i_acc       (acc),
        .i_out_free  (out_free),
        .o_busy      (busy),
        .o_add       (add_ctl),
        .o_emit      (emit),
        .o_emit_word (emit_word)
    );

    // result register: parts the sequencer from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= emit_word;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> design/gbig_regs.sv
module gbig_regs
    import gbig_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output t_dims             o_dims
);

    logic [CNT_W-1:0] r_count_u;
    logic [CNT_W-1:0] r_count_v;
    logic [CNT_W-1:0] r_count_w;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_u <= CNT_W'(2);
            r_count_v <= CNT_W'(2);
            r_count_w <= CNT_W'(2);
        end else if (wr_en) begin
            case (reg_idx)
                REG_COUNT_U: r_count_u <= pwdata[CNT_W-1:0];
                REG_COUNT_V: r_count_v <= pwdata[CNT_W-1:0];
                REG_COUNT_W: r_count_w <= pwdata[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COUNT_U: prdata = DATA_W'(r_count_u);
            REG_COUNT_V: prdata = DATA_W'(r_count_v);
            REG_COUNT_W: prdata = DATA_W'(r_count_w);
            default:     prdata = '0;
        endcase
    end

    assign o_dims.nu = clamp_count(r_count_u);
    assign o_dims.nv = clamp_count(r_count_v);
    assign o_dims.nw = clamp_count(r_count_w);

endmodule

>>> design/gbig_addu.sv
module gbig_addu
    import gbig_pkg::*;
(
    input  logic             i_clk,
    input  t_add_ctl         i_ctl,
    output logic [IDX_W-1:0] o_acc
);

    logic [IDX_W-1:0] r_acc;
    logic [IDX_W-1:0] r_row;   // start of the current face row
    logic [IDX_W-1:0] opa;
    logic [IDX_W-1:0] sum;

    always_comb begin
        case (i_ctl.a_sel)
            ASEL_ACC: opa = r_acc;
            ASEL_ROW: opa = r_row;
            default:  opa = '0;
        endcase
    end

    // indices never pass 511, so the carry out is never needed
    assign sum = IDX_W'(opa + i_ctl.b);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_acc) begin
            r_acc <= sum;
        end
        if (i_ctl.load_row) begin
            r_row <= sum;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> design/gbig_seq.sv
module gbig_seq
    import gbig_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_word         i_req,
    input  t_dims            i_dims,
    input  logic [IDX_W-1:0] i_acc,
    input  logic             i_out_free,
    output logic             o_busy,
    output t_add_ctl         o_add,
    output logic             o_emit,
    output t_out_word        o_emit_word
);

    t_state              r_state;
    t_state              n_state;
    t_mode               r_mode;
    logic [3:0]          r_sel;
    logic [1:0]          r_pick;
    logic [POS_W-1:0]    r_i;
    logic [POS_W-1:0]    r_j;
    logic [PLANE_W-1:0]  r_plane;
    logic [PLANE_W-1:0]  r_dv;     // nu*(nv-1): v at its far end
    logic [IDX_W-1:0]    r_dw;     // nu*nv*(nw-1): w at its far end

    logic [VTX_W-1:0]    vtx;
    logic                pick_last;
    logic                walk;
    t_axis               ax_in;
    t_axis               ax_out;
    logic [POS_W-1:0]    li_m1;
    logic [POS_W-1:0]    lo_m1;
    logic [IDX_W-1:0]    si;
    logic [IDX_W-1:0]    so;
    logic                j_end;
    logic                i_end;
    logic                w_last;

    function automatic logic [POS_W-1:0] len_m1(input t_axis a, input t_dims d);
        logic [CNT_W-1:0] n;
        case (a)
            AXIS_U:  n = d.nu;
            AXIS_V:  n = d.nv;
            default: n = d.nw;
        endcase
        return POS_W'(n - CNT_W'(1));
    endfunction

    function automatic logic [IDX_W-1:0] stride(input t_axis a, input t_dims d,
                                                input logic [PLANE_W-1:0] plane);
        logic [IDX_W-1:0] s;
        case (a)
            AXIS_U:  s = IDX_W'(1);
            AXIS_V:  s = IDX_W'(d.nu);
            default: s = IDX_W'(plane);
        endcase
        return s;
    endfunction

    assign vtx       = vertex_of(r_mode, r_sel, r_pick);
    assign walk      = (r_mode == MODE_EDGE_RUN) || (r_mode == MODE_FACE_RUN);
    assign pick_last = (r_mode == MODE_EDGE_ENDS)    ? (r_pick == 2'd1) :
                       (r_mode == MODE_FACE_CORNERS) ? (r_pick == 2'd3) : 1'b1;

    // edges walk one row, faces walk outer by inner
    assign ax_in  = (r_mode == MODE_FACE_RUN) ? face_inner_of(r_sel) : edge_axis_of(r_sel);
    assign ax_out = face_outer_of(r_sel);
    assign li_m1  = len_m1(ax_in, i_dims);
    assign lo_m1  = (r_mode == MODE_FACE_RUN) ? len_m1(ax_out, i_dims) : '0;
    assign si     = stride(ax_in, i_dims, r_plane);
    assign so     = stride(ax_out, i_dims, r_plane);
    assign j_end  = (r_j == li_m1);
    assign i_end  = (r_i == lo_m1);
    assign w_last = j_end & i_end;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = req_ok(i_req.mode, i_req.selector) ? S_PLANE : S_BAD;
                end
            end
            S_PLANE: n_state = S_OFFS;
            S_OFFS:  n_state = S_VX0;
            S_VX0:   n_state = S_VX1;
            S_VX1:   n_state = S_VX2;
            S_VX2:   n_state = walk ? S_WALK : S_PUT;
            S_PUT: begin
                if (i_out_free) begin
                    n_state = pick_last ? S_IDLE : S_VX0;
                end
            end
            S_WALK: begin
                if (i_out_free && w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_BAD: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_add       = '{a_sel: ASEL_ZERO, b: '0, load_acc: 1'b0, load_row: 1'b0};
        o_emit      = 1'b0;
        o_emit_word = '0;
        case (r_state)
            S_VX0: begin
                o_add.b        = vtx[0] ? IDX_W'(i_dims.nu - CNT_W'(1)) : '0;
                o_add.load_acc = 1'b1;
            end
            S_VX1: begin
                o_add.a_sel    = ASEL_ACC;
                o_add.b        = vtx[1] ? r_dw : '0;
                o_add.load_acc = 1'b1;
            end
            S_VX2: begin
                o_add.a_sel    = ASEL_ACC;
                o_add.b        = vtx[2] ? IDX_W'(r_dv) : '0;
                o_add.load_acc = 1'b1;
                o_add.load_row = walk;
            end
            S_PUT: begin
                o_emit                  = i_out_free;
                o_emit_word.basis_index = i_acc;
                o_emit_word.last        = pick_last;
            end
            S_WALK: begin
                o_emit                  = i_out_free;
                o_emit_word.basis_index = i_acc;
                o_emit_word.row_end     = (r_mode == MODE_FACE_RUN) && j_end;
                o_emit_word.last        = w_last;
                if (i_out_free && !w_last) begin
                    o_add.load_acc = 1'b1;
                    if (j_end) begin
                        o_add.a_sel    = ASEL_ROW;
                        o_add.b        = so;
                        o_add.load_row = 1'b1;
                    end else begin
                        o_add.a_sel = ASEL_ACC;
                        o_add.b     = si;
                    end
                end
            end
            S_BAD: begin
                o_emit                  = i_out_free;
                o_emit_word.last        = 1'b1;
                o_emit_word.bad_request = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_mode <= t_mode'(i_req.mode);
                    r_sel  <= i_req.selector;
                    r_pick <= '0;
                    r_i    <= '0;
                    r_j    <= '0;
                end
            end
            S_PLANE: begin
                r_plane <= PLANE_W'(i_dims.nu) * PLANE_W'(i_dims.nv);
            end
            S_OFFS: begin
                r_dw <= IDX_W'(r_plane) * IDX_W'(i_dims.nw - CNT_W'(1));
                r_dv <= PLANE_W'(r_plane - PLANE_W'(i_dims.nu));
            end
            S_PUT: begin
                if (i_out_free && !pick_last) begin
                    r_pick <= r_pick + 2'd1;
                end
            end
            S_WALK: begin
                if (i_out_free && !w_last) begin
                    if (j_end) begin
                        r_j <= '0;
                        r_i <= r_i + POS_W'(1);
                    end else begin
                        r_j <= r_j + POS_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> design/gbig_checker.sv
`include "grid_boundary_index_generator_defines.svh"

module gbig_checker
    import gbig_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a taken request keeps the request side stalled for its burst
    `GBIG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // rejected requests give a zero index, flagged final, no row end
    `GBIG_ASSERT_NOW(a_bad_form, i_clk, i_rst_n, o_out_valid && o_out_word.bad_request, o_out_word.last && !o_out_word.row_end && (o_out_word.basis_index == 9'd0))

    // only a burst's final word can still wait once the block is idle
    `GBIG_ASSERT_NOW(a_idle_holds_last, i_clk, i_rst_n, o_out_valid && !o_in_stall, o_out_word.last)

    // a stalled result holds
    `GBIG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

endmodule

bind grid_boundary_index_generator gbig_checker u_gbig_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

>>> verif/grid_boundary_index_generator_tb.sv
`timescale 1ns / 100ps

module grid_boundary_index_generator_tb
    import gbig_pkg::*;
();

    localparam int N_VERTS         = 8;
    localparam int N_EDGES         = 12;
    localparam int N_FACES         = 6;
    localparam int MAX_GAP         = 11;   // longest idle stretch per word, either side
    localparam int SETTLE_CYCLES   = 8;    // quiet time before a register write
    localparam int END_CYCLES      = 16;   // quiet time before the verdict
    localparam int WATCHDOG_LIMIT  = 1000; // cycles with no handshake at all
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 24;

    // mode codes the block has no use for; they must come back as bad requests
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // edge k runs along EDGE_DIR[k] from corner EDGE_FROM[k] to corner EDGE_TO[k]
    localparam t_axis EDGE_DIR [N_EDGES] = '{AXIS_U, AXIS_U, AXIS_W, AXIS_W,
                                             AXIS_U, AXIS_U, AXIS_W, AXIS_W,
                                             AXIS_V, AXIS_V, AXIS_V, AXIS_V};
    localparam int EDGE_FROM [N_EDGES] = '{0, 2, 0, 1, 4, 6, 4, 5, 0, 1, 2, 3};
    localparam int EDGE_TO   [N_EDGES] = '{1, 3, 2, 3, 5, 7, 6, 7, 4, 5, 6, 7};

    // face k: rows step along FACE_ROW_DIR, each row along FACE_COL_DIR, from FACE_ORIGIN
    localparam t_axis FACE_ROW_DIR [N_FACES] = '{AXIS_W, AXIS_W, AXIS_V,
                                                 AXIS_V, AXIS_V, AXIS_V};
    localparam t_axis FACE_COL_DIR [N_FACES] = '{AXIS_U, AXIS_U, AXIS_W,
                                                 AXIS_W, AXIS_U, AXIS_U};
    localparam int FACE_ORIGIN [N_FACES] = '{0, 4, 0, 1, 0, 2};
    // four corners per face, in emit order
    localparam int FACE_CORNER [N_FACES*4] = '{0, 1, 3, 2,   4, 5, 7, 6,
                                               0, 2, 6, 4,   1, 3, 7, 5,
                                               0, 1, 5, 4,   2, 3, 7, 6};

    // directed stimulus: a request plus, for one-word answers that are obvious,
    // the result word typed in by hand
    typedef struct packed {
        t_in_word  req;
        logic      typed;
        t_out_word want;
    } t_dir_row;

    localparam t_out_word NO_WORD  = '0;
    localparam t_out_word BAD_WORD = '{basis_index: '0, row_end: 1'b0,
                                       last: 1'b1, bad_request: 1'b1};
    localparam int DIR_ROWS = 21;

    // rows assume the reset grid of 2 x 2 x 2
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{'{MODE_VERTEX,       4'd0},  1'b1, '{9'd0, 1'b0, 1'b1, 1'b0}},
        '{'{MODE_VERTEX,       4'd7},  1'b1, '{9'd7, 1'b0, 1'b1, 1'b0}},
        '{'{MODE_VERTEX,       4'd2},  1'b1, '{9'd4, 1'b0, 1'b1, 1'b0}},
        '{'{MODE_VERTEX,       4'd15}, 1'b1, BAD_WORD},
        '{'{MODE_VERTEX,       4'd8},  1'b1, BAD_WORD},
        '{'{MODE_EDGE_RUN,     4'd0},  1'b0, NO_WORD},
        '{'{MODE_EDGE_RUN,     4'd11}, 1'b0, NO_WORD},
        '{'{MODE_EDGE_RUN,     4'd12}, 1'b1, BAD_WORD},
        '{'{MODE_EDGE_RUN,     4'd3},  1'b0, NO_WORD},
        '{'{MODE_FACE_RUN,     4'd0},  1'b0, NO_WORD},
        '{'{MODE_FACE_RUN,     4'd3},  1'b0, NO_WORD},
        '{'{MODE_FACE_RUN,     4'd5},  1'b0, NO_WORD},
        '{'{MODE_FACE_RUN,     4'd6},  1'b1, BAD_WORD},
        '{'{MODE_EDGE_ENDS,    4'd0},  1'b0, NO_WORD},
        '{'{MODE_EDGE_ENDS,    4'd11}, 1'b0, NO_WORD},
        '{'{MODE_EDGE_ENDS,    4'd12}, 1'b1, BAD_WORD},
        '{'{MODE_FACE_CORNERS, 4'd0},  1'b0, NO_WORD},
        '{'{MODE_FACE_CORNERS, 4'd5},  1'b0, NO_WORD},
        '{'{MODE_FACE_CORNERS, 4'd6},  1'b1, BAD_WORD},
        '{'{MODE_SPARE_LO,     4'd0},  1'b1, BAD_WORD},
        '{'{MODE_SPARE_HI,     4'd15}, 1'b1, BAD_WORD}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_word          i_in_word;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_word         o_out_word;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // local copy of the grid size registers, raw as written
    logic [CNT_W-1:0] grid_u = 4'd2;
    logic [CNT_W-1:0] grid_v = 4'd2;
    logic [CNT_W-1:0] grid_w = 4'd2;

    t_out_word pending_results [$];   // result words owed by the block, oldest first
    int        mismatch_count = 0;
    bit        gaps_on        = 1'b1; // off gives back-to-back stretches on both sides
    bit        result_taken   = 1'b0;
    int        stall_left     = 0;
    int        quiet_cycles   = 0;

    grid_boundary_index_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    // a zero count behaves as one, anything past the maximum as the maximum
    function automatic int grid_size(input logic [CNT_W-1:0] c);
        int n;
        n = int'(c);
        if (n < 1) begin
            n = 1;
        end else if (n > MAX_BASIS_PER_DIR) begin
            n = MAX_BASIS_PER_DIR;
        end
        return n;
    endfunction

    function automatic int corner_index(input int k, input int nu, input int nv,
                                        input int nw);
        int idx;
        case (k)
            0:       idx = 0;
            1:       idx = nu - 1;
            2:       idx = nu * nv * (nw - 1);
            3:       idx = nu * nv * (nw - 1) + nu - 1;
            4:       idx = nu * (nv - 1);
            5:       idx = nu * nv - 1;
            6:       idx = nu * nv * nw - nu;
            default: idx = nu * nv * nw - 1;
        endcase
        return idx;
    endfunction

    function automatic int axis_step(input t_axis a, input int nu, input int nv);
        int s;
        case (a)
            AXIS_U:  s = 1;
            AXIS_V:  s = nu;
            default: s = nu * nv;
        endcase
        return s;
    endfunction

    function automatic int axis_span(input t_axis a, input int nu, input int nv,
                                     input int nw);
        int s;
        case (a)
            AXIS_U:  s = nu;
            AXIS_V:  s = nv;
            default: s = nw;
        endcase
        return s;
    endfunction

    function automatic void owe_word(input int idx, input bit re, input bit la,
                                     input bit bad);
        t_out_word w;
        w.basis_index = IDX_W'(idx);
        w.row_end     = re;
        w.last        = la;
        w.bad_request = bad;
        pending_results.insert(pending_results.size(), w);
    endfunction

    // queue the full burst of result words one request must produce
    function automatic void enumerate_boundary(input t_in_word req);
        int nu, nv, nw, sel, base, row_step, col_step, rows, cols, i, j;
        bit handled;
        nu      = grid_size(grid_u);
        nv      = grid_size(grid_v);
        nw      = grid_size(grid_w);
        sel     = int'(req.selector);
        handled = 1'b0;
        case (req.mode)
            MODE_VERTEX: begin
                if (sel < N_VERTS) begin
                    owe_word(corner_index(sel, nu, nv, nw), 1'b0, 1'b1, 1'b0);
                    handled = 1'b1;
                end
            end
            MODE_EDGE_RUN: begin
                if (sel < N_EDGES) begin
                    base     = corner_index(EDGE_FROM[sel], nu, nv, nw);
                    col_step = axis_step(EDGE_DIR[sel], nu, nv);
                    cols     = axis_span(EDGE_DIR[sel], nu, nv, nw);
                    for (i = 0; i < cols; i++) begin
                        owe_word(base + i * col_step, 1'b0, i == cols - 1, 1'b0);
                    end
                    handled = 1'b1;
                end
            end
            MODE_FACE_RUN: begin
                if (sel < N_FACES) begin
                    base     = corner_index(FACE_ORIGIN[sel], nu, nv, nw);
                    row_step = axis_step(FACE_ROW_DIR[sel], nu, nv);
                    col_step = axis_step(FACE_COL_DIR[sel], nu, nv);
                    rows     = axis_span(FACE_ROW_DIR[sel], nu, nv, nw);
                    cols     = axis_span(FACE_COL_DIR[sel], nu, nv, nw);
                    for (i = 0; i < rows; i++) begin
                        for (j = 0; j < cols; j++) begin
                            owe_word(base + i * row_step + j * col_step, j == cols - 1,
                                     (j == cols - 1) && (i == rows - 1), 1'b0);
                        end
                    end
                    handled = 1'b1;
                end
            end
            MODE_EDGE_ENDS: begin
                if (sel < N_EDGES) begin
                    owe_word(corner_index(EDGE_FROM[sel], nu, nv, nw), 1'b0, 1'b0, 1'b0);
                    owe_word(corner_index(EDGE_TO[sel], nu, nv, nw), 1'b0, 1'b1, 1'b0);
                    handled = 1'b1;
                end
            end
            MODE_FACE_CORNERS: begin
                if (sel < N_FACES) begin
                    for (i = 0; i < 4; i++) begin
                        owe_word(corner_index(FACE_CORNER[sel*4 + i], nu, nv, nw),
                                 1'b0, i == 3, 1'b0);
                    end
                    handled = 1'b1;
                end
            end
            default: ;
        endcase
        // selector out of range, or a spare mode: one flagged word
        if (!handled) begin
            owe_word(0, 1'b0, 1'b1, 1'b1);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    // mostly well-formed requests; some noise over the full field ranges
    function automatic t_in_word random_request();
        t_in_word w;
        if ($urandom_range(0, 99) < 15) begin
            w.mode     = 3'($urandom_range(0, 7));
            w.selector = 4'($urandom_range(0, 15));
        end else begin
            w.mode = 3'($urandom_range(int'(MODE_VERTEX), int'(MODE_FACE_CORNERS)));
            case (w.mode)
                MODE_VERTEX:                   w.selector = 4'($urandom_range(0, N_VERTS - 1));
                MODE_EDGE_RUN, MODE_EDGE_ENDS: w.selector = 4'($urandom_range(0, N_EDGES - 1));
                default:                       w.selector = 4'($urandom_range(0, N_FACES - 1));
            endcase
        end
        return w;
    endfunction

    // small grids most of the time, so face walks stay short
    function automatic logic [CNT_W-1:0] random_size();
        logic [CNT_W-1:0] c;
        case ($urandom_range(0, 9))
            0:       c = '0;
            1:       c = CNT_W'($urandom_range(MAX_BASIS_PER_DIR + 1, 15));
            2:       c = CNT_W'(MAX_BASIS_PER_DIR);
            default: c = CNT_W'($urandom_range(1, 4));
        endcase
        return c;
    endfunction

    // Drive one request word after a random gap, hold it through any stall, and
    // book its result words at the accepting edge. A typed row books its word as is.
    task automatic send_request(input t_in_word w, input bit typed, input t_out_word want);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        if (typed) begin
            pending_results.insert(pending_results.size(), want);
        end else begin
            enumerate_boundary(w);
        end
    endtask

    // drop valid and let the block finish everything it owes
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready; junk above the count field
    task automatic write_count(input t_reg_idx r, input logic [CNT_W-1:0] val);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(r));
        pwdata  <= {junk[DATA_W-1:CNT_W], val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (r)
            REG_COUNT_U: grid_u = val;
            REG_COUNT_V: grid_v = val;
            default:     grid_w = val;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_grid(input logic [CNT_W-1:0] u, input logic [CNT_W-1:0] v,
                            input logic [CNT_W-1:0] w);
        write_count(REG_COUNT_U, u);
        write_count(REG_COUNT_V, v);
        write_count(REG_COUNT_W, w);
    endtask

    // ---------------------------------------------------------------- result side

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %p",
                         $time, o_out_word);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("basis_index", want.basis_index, o_out_word.basis_index);
                check_field("row_end", want.row_end, o_out_word.row_end);
                check_field("last", want.last, o_out_word.last);
                check_field("bad_request", want.bad_request, o_out_word.bad_request);
            end
            result_taken = 1'b1;
        end
    end

    // receiver back-pressure: a fresh stall count after every taken result word
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (result_taken) begin
                result_taken = 1'b0;
                stall_left   = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog: any handshake on any port counts as progress
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d result words still pending",
                     $time, pending_results.size());
            $display("grid_boundary_index_generator_tb: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        int r, ph, k;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass on the reset grid
        for (r = 0; r < DIR_ROWS; r++) begin
            send_request(DIR_TABLE[r].req, DIR_TABLE[r].typed, DIR_TABLE[r].want);
        end

        // Random phases, each on its own grid. The first few pin the extremes,
        // including a zero count and counts past the maximum.
        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       set_grid(4'd1, 4'd1, 4'd1);
                1:       set_grid(4'd8, 4'd8, 4'd8);
                2:       set_grid(4'd0, 4'd15, 4'd9);
                3:       set_grid(4'd15, 4'd0, 4'd8);
                default: set_grid(random_size(), random_size(), random_size());
            endcase
            // full-size grid runs flat out; other phases mostly get random gaps on both sides
            gaps_on = (ph != 1) && ($urandom_range(0, 3) != 0);
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                // hold off once mid-phase until the block is completely empty
                if (ph == 4 && k == WORDS_PER_PHASE / 2) begin
                    wait_drained();
                end
                send_request(random_request(), 1'b0, NO_WORD);
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("grid_boundary_index_generator_tb: done, clean");
        end else begin
            $display("grid_boundary_index_generator_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> grid_boundary_index_generator.f
+incdir+design
design/gbig_pkg.sv
design/gbig_regs.sv
design/gbig_addu.sv
design/gbig_seq.sv
design/grid_boundary_index_generator.sv
design/gbig_checker.sv
verif/grid_boundary_index_generator_tb.sv
